FILE: rtl/core/lsce_pkg.sv
// Shared constants and types of the line sensor centroid error unit.
package lsce_pkg;

  localparam int unsigned NumSensors = 6;
  localparam int unsigned SampleW    = 8;
  // Plain sum of six 8-bit samples: at most 1530.
  localparam int unsigned SumW       = 11;
  // Weighted sum: at most +/-40800, two's complement.
  localparam int unsigned WsumW      = 17;
  localparam int unsigned MagW       = 16;
  // Quotient magnitude is at most 100.
  localparam int unsigned QuotW      = 7;
  localparam int unsigned ErrW       = 8;
  // Widest shifted divisor seen by the first divide step.
  localparam int unsigned DshW       = SumW + QuotW - 1;

  localparam int signed Weights [NumSensors] = '{-100, -40, -20, 20, 40, 100};

  localparam logic [SampleW-1:0] ThreshReset = 8'd128;

  // Payload of one divide step.
  typedef struct packed {
    logic [SumW-1:0]  total;
    logic [MagW-1:0]  rem;
    logic [QuotW-1:0] quo;
    logic             neg;
    logic             hit;
  } div_t;

endpackage

FILE: rtl/core/lsce_if.sv
// Stream and configuration interfaces of the line sensor centroid error unit.
interface lsce_sample_if;
  logic                             valid;
  logic                             ready;
  logic [lsce_pkg::SampleW-1:0]     sample_0;
  logic [lsce_pkg::SampleW-1:0]     sample_1;
  logic [lsce_pkg::SampleW-1:0]     sample_2;
  logic [lsce_pkg::SampleW-1:0]     sample_3;
  logic [lsce_pkg::SampleW-1:0]     sample_4;
  logic [lsce_pkg::SampleW-1:0]     sample_5;

  modport source (output valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
                  input ready);
  modport sink   (input valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
                  output ready);
endinterface

interface lsce_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [lsce_pkg::ErrW-1:0] position_error;
  logic                             line_found;
  logic                             above_threshold;

  modport source (output valid, position_error, line_found, above_threshold, input ready);
  modport sink   (input valid, position_error, line_found, above_threshold, output ready);
endinterface

interface lsce_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lsce_pkg::SampleW-1:0]     detect_threshold;

  modport source (output valid, detect_threshold, input ready);
  modport sink   (input valid, detect_threshold, output ready);
endinterface

FILE: rtl/core/line_sensor_centroid_error_unit.sv
// Top level of the line sensor centroid error unit.

// Takes one row of six 8-bit line sensor samples per transfer and returns one
// result per row: the centroid position error, weighted sum over plain sum
// truncated toward zero (weights -100, -40, -20, 20, 40, 100 from left to
// right), in -100..100; line_found, low when all samples are zero (the error
// is then 0); and above_threshold, high when any sample is at or above
// detect_threshold (reset value 128). The unit accepts one row every cycle
// unless a stall on the result side has backed up to the input, and each
// row's result passes ten register stages: the input transfer loads the
// stage that holds the sums, one stage takes the magnitude of the weighted
// sum, seven restoring-divide stages each resolve one quotient bit, and the
// output register applies the sign. Every stage carries its own valid bit and
// advances whenever the stage after it is empty or moving, so bubbles close
// up and a stall on the result side backs up without loss. The threshold
// port always takes a transfer; write it only while the unit is idle.
module line_sensor_centroid_error_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  lsce_sample_if.sink        sample_i,
  lsce_cfg_if.sink           cfg_i,
  lsce_result_if.source      result_o
);

  localparam int unsigned Last = lsce_pkg::QuotW - 1;

  // Threshold register: always ready, load on transfer.
  logic [lsce_pkg::SampleW-1:0] thresh_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= lsce_pkg::ThreshReset;
    end else if (cfg_i.valid) begin
      thresh_q <= cfg_i.detect_threshold;
    end
  end

  // Flow control: a stage is free when it is empty or its content moves on.
  logic                     out_free;
  logic [lsce_pkg::QuotW-1:0] div_free;
  logic                     s2_free;
  logic                     s1_free;

  logic                     out_v_q;
  logic [lsce_pkg::QuotW-1:0] dv_v_q;
  logic                     s2_v_q;
  logic                     s1_v_q;

  always_comb begin
    out_free = !out_v_q || result_o.ready;
    div_free[Last] = !dv_v_q[Last] || out_free;
    for (int k = Last - 1; k >= 0; k--) begin
      div_free[k] = !dv_v_q[k] || div_free[k+1];
    end
    s2_free = !s2_v_q || div_free[0];
    s1_free = !s1_v_q || s2_free;
  end

  assign sample_i.ready = s1_free;

  // Stage 1: plain sum, weighted sum and threshold hit.
  logic [lsce_pkg::SampleW-1:0]      samp [lsce_pkg::NumSensors];
  logic [lsce_pkg::SumW-1:0]         total_d, s1_total_q;
  logic signed [lsce_pkg::WsumW-1:0] wsum_d, s1_wsum_q;
  logic                              hit_d, s1_hit_q;

  assign samp[0] = sample_i.sample_0;
  assign samp[1] = sample_i.sample_1;
  assign samp[2] = sample_i.sample_2;
  assign samp[3] = sample_i.sample_3;
  assign samp[4] = sample_i.sample_4;
  assign samp[5] = sample_i.sample_5;

  always_comb begin
    total_d = '0;
    wsum_d  = '0;
    hit_d   = 1'b0;
    for (int i = 0; i < lsce_pkg::NumSensors; i++) begin
      total_d = total_d + lsce_pkg::SumW'(samp[i]);
      wsum_d  = wsum_d + lsce_pkg::WsumW'(lsce_pkg::Weights[i] * $signed({1'b0, samp[i]}));
      hit_d   = hit_d | (samp[i] >= thresh_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_free) begin
      s1_v_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && sample_i.valid) begin
      s1_total_q <= total_d;
      s1_wsum_q  <= wsum_d;
      s1_hit_q   <= hit_d;
    end
  end

  // Stage 2: split the weighted sum into sign and magnitude.
  logic [lsce_pkg::WsumW-1:0] mag_full;
  lsce_pkg::div_t             s2_q;

  assign mag_full = s1_wsum_q[lsce_pkg::WsumW-1] ? -s1_wsum_q : s1_wsum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_free) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && s1_v_q) begin
      s2_q.total <= s1_total_q;
      s2_q.rem   <= mag_full[lsce_pkg::MagW-1:0];
      s2_q.quo   <= '0;
      s2_q.neg   <= s1_wsum_q[lsce_pkg::WsumW-1];
      s2_q.hit   <= s1_hit_q;
    end
  end

  // Divide stages: stage k resolves quotient bit Last-k by compare and subtract.
  lsce_pkg::div_t dv_q [lsce_pkg::QuotW];

  for (genvar k = 0; k < lsce_pkg::QuotW; k++) begin : g_div
    localparam int unsigned Bit = Last - k;

    lsce_pkg::div_t            prev;
    logic                      prev_v;
    logic [lsce_pkg::DshW-1:0] dsh;
    logic                      take;
    lsce_pkg::div_t            nxt;

    if (k == 0) begin : g_first
      assign prev   = s2_q;
      assign prev_v = s2_v_q;
    end else begin : g_rest
      assign prev   = dv_q[k-1];
      assign prev_v = dv_v_q[k-1];
    end

    assign dsh  = lsce_pkg::DshW'(prev.total) << Bit;
    assign take = lsce_pkg::DshW'(prev.rem) >= dsh;

    always_comb begin
      nxt = prev;
      if (take) begin
        nxt.rem      = prev.rem - dsh[lsce_pkg::MagW-1:0];
        nxt.quo[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k] <= 1'b0;
      end else if (div_free[k]) begin
        dv_v_q[k] <= prev_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (div_free[k] && prev_v) begin
        dv_q[k] <= nxt;
      end
    end
  end

  // Output register: apply the sign, force zero when the line is lost.
  logic                            found;
  logic [lsce_pkg::ErrW-1:0]       quo_ext;
  logic signed [lsce_pkg::ErrW-1:0] err_d, err_q;
  logic                            found_q;
  logic                            hit_q;

  assign found   = dv_q[Last].total != '0;
  assign quo_ext = {1'b0, dv_q[Last].quo};

  always_comb begin
    if (!found) begin
      err_d = '0;
    end else if (dv_q[Last].neg) begin
      err_d = -quo_ext;
    end else begin
      err_d = quo_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= dv_v_q[Last];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && dv_v_q[Last]) begin
      err_q   <= err_d;
      found_q <= found;
      hit_q   <= dv_q[Last].hit;
    end
  end

  assign result_o.valid           = out_v_q;
  assign result_o.position_error  = err_q;
  assign result_o.line_found      = found_q;
  assign result_o.above_threshold = hit_q;

  // A zero plain sum can only come from an all-zero row.
  a_zero_sum_zero_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && (s2_q.total == '0) |-> (s2_q.rem == '0))
    else $error("zero sample sum with nonzero weighted magnitude");

  // After the last divide step the remainder is below the divisor.
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v_q[Last] && (dv_q[Last].total != '0) |-> (dv_q[Last].rem < dv_q[Last].total))
    else $error("divide pipeline left remainder not below divisor");

  // A full pipeline behind a stalled result refuses new rows.
  a_full_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !result_o.ready && (&dv_v_q) && s2_v_q && s1_v_q |-> !sample_i.ready)
    else $error("row accepted while every stage is stalled");

  // A found line always yields an error within -100..100.
  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v_q[Last] && (dv_q[Last].total != '0) |-> (dv_q[Last].quo <= lsce_pkg::QuotW'(100)))
    else $error("quotient magnitude out of range");

endmodule
